// File: hdl/hcd_pkg.sv
// Package: shared types and constants for the chunked body decoder.
`timescale 1ns / 1ps

package hcd_pkg;

    // Default width of the chunk size counter
    localparam int SIZE_BITS_DEF = 32;

    // Line terminator and blank bytes
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    // Decoder phases
    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_DATA = 3'd1,
        PH_CRLF = 3'd2,
        PH_DONE = 3'd3,
        PH_ERR  = 3'd4
    } hcd_phase_t;

    // Classification of one raw byte
    typedef struct packed {
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_blank;
        logic       is_cr;
        logic       is_lf;
    } hcd_class_t;

endpackage

// File: hdl/hcd_if.sv
// Interfaces: request channel for body bytes and result channel.
`timescale 1ns / 1ps

interface hcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       body_start;

    modport source (output valid, output in_byte, output body_start, input ready);
    modport sink (input valid, input in_byte, input body_start, output ready);
endinterface

interface hcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    logic       format_error;

    modport source (output valid, output out_byte, output out_valid, output done_res,
                    output format_error, input ready);
    modport sink (input valid, input out_byte, input out_valid, input done_res,
                  input format_error, output ready);
endinterface

// File: hdl/http_chunked_body_decoder.sv
// Top level: chunked transfer body decoder, one byte per request.
`timescale 1ns / 1ps

// Takes up to one body byte per cycle and returns one result per byte, in
// the cycle after it is taken, from a single output register. A new request
// is accepted in every cycle in which the output register is empty or its
// result is being taken, so the sustained rate is one byte per cycle; the
// phase and size registers hold the decoder state between bytes, and the
// result register holds the result. Set body_start on the first body byte
// of each message to restart decoding. Once done_res or format_error shows,
// further bytes are consumed with no payload until the next body_start.
module http_chunked_body_decoder
    import hcd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    hcd_in_if.sink       body,
    hcd_out_if.source    result
);

    hcd_phase_t            phase_reg, phase_next;
    logic [SIZE_BITS-1:0]  rem_reg, rem_next;
    logic                  seen_reg, seen_next;
    logic                  stopped_reg, stopped_next;
    logic                  pcr_reg, pcr_next;
    logic                  trail_reg, trail_next;

    logic                  res_valid_reg;
    logic [7:0]            res_byte_reg, res_byte_next;
    logic                  res_ov_reg, res_ov_next;
    logic                  res_done_reg, res_done_next;
    logic                  res_err_reg, res_err_next;

    logic                  accept;
    hcd_class_t            cls;

    // Effective state after an optional restart
    hcd_phase_t            cur_phase;
    logic [SIZE_BITS-1:0]  cur_rem;
    logic                  cur_seen;
    logic                  cur_stopped;
    logic                  cur_pcr;
    logic                  cur_trail;
    logic [SIZE_BITS-1:0]  rem_shifted;
    logic [SIZE_BITS-1:0]  rem_dec;

    hcd_byte_class u_class (
        .byte_in (body.in_byte),
        .cls     (cls)
    );

    // Accept while the result register is free or draining
    assign body.ready = !res_valid_reg || result.ready;
    assign accept     = body.valid && body.ready;

    // Drive result channel
    assign result.valid        = res_valid_reg;
    assign result.out_byte     = res_byte_reg;
    assign result.out_valid    = res_ov_reg;
    assign result.done_res     = res_done_reg;
    assign result.format_error = res_err_reg;

    // Apply restart on body_start
    always_comb
    begin
        if (body.body_start)
        begin
            cur_phase   = PH_SIZE;
            cur_rem     = '0;
            cur_seen    = 1'b0;
            cur_stopped = 1'b0;
            cur_pcr     = 1'b0;
            cur_trail   = 1'b0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_rem     = rem_reg;
            cur_seen    = seen_reg;
            cur_stopped = stopped_reg;
            cur_pcr     = pcr_reg;
            cur_trail   = trail_reg;
        end
    end

    // Shift in one hex digit, saturating on overflow
    assign rem_shifted = (|cur_rem[SIZE_BITS-1 -: 4]) ? {SIZE_BITS{1'b1}}
                                                      : {cur_rem[SIZE_BITS-5:0], cls.hex_val};
    assign rem_dec     = cur_rem - {{(SIZE_BITS-1){1'b0}}, 1'b1};

    // Next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        rem_next      = rem_reg;
        seen_next     = seen_reg;
        stopped_next  = stopped_reg;
        pcr_next      = pcr_reg;
        trail_next    = trail_reg;
        res_byte_next = 8'h00;
        res_ov_next   = 1'b0;
        if (accept)
        begin
            phase_next   = cur_phase;
            rem_next     = cur_rem;
            seen_next    = cur_seen;
            stopped_next = cur_stopped;
            pcr_next     = cur_pcr;
            trail_next   = cur_trail;
            unique case (cur_phase)
                PH_SIZE:
                begin
                    if (cur_pcr && cls.is_lf)
                    begin
                        pcr_next     = 1'b0;
                        seen_next    = 1'b0;
                        stopped_next = 1'b0;
                        phase_next   = (cur_rem == '0) ? PH_DONE : PH_DATA;
                    end
                    else
                    begin
                        pcr_next = cls.is_cr;
                        if (!cur_stopped)
                        begin
                            if (cls.is_hex)
                            begin
                                rem_next  = rem_shifted;
                                seen_next = 1'b1;
                            end
                            else if (!(!cur_seen && cls.is_blank))
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    res_byte_next = body.in_byte;
                    res_ov_next   = 1'b1;
                    rem_next      = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_CRLF;
                        trail_next = 1'b0;
                        pcr_next   = 1'b0;
                    end
                end
                PH_CRLF:
                begin
                    if (!cur_trail)
                    begin
                        pcr_next   = cls.is_cr;
                        trail_next = 1'b1;
                    end
                    else
                    begin
                        trail_next = 1'b0;
                        pcr_next   = 1'b0;
                        if (cur_pcr && cls.is_lf)
                        begin
                            phase_next   = PH_SIZE;
                            rem_next     = '0;
                            seen_next    = 1'b0;
                            stopped_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                        end
                    end
                end
                PH_DONE, PH_ERR:
                begin
                    // drop the byte
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
        end
        res_done_next = (phase_next == PH_DONE);
        res_err_next  = (phase_next == PH_ERR);
    end

    // Hold decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIZE;
            rem_reg     <= '0;
            seen_reg    <= 1'b0;
            stopped_reg <= 1'b0;
            pcr_reg     <= 1'b0;
            trail_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
            seen_reg    <= seen_next;
            stopped_reg <= stopped_next;
            pcr_reg     <= pcr_next;
            trail_reg   <= trail_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (body.ready)
        begin
            res_valid_reg <= body.valid;
        end
    end

    // Result payload: load on each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_byte_reg <= res_byte_next;
            res_ov_reg   <= res_ov_next;
            res_done_reg <= res_done_next;
            res_err_reg  <= res_err_next;
        end
    end

    // Data phase always has bytes still due
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("data phase with zero bytes remaining");

    // Trailer byte count only lives in the CR LF phase
    a_trail_phase: assert property (@(posedge clk) disable iff (!rst_n)
        trail_reg |-> phase_reg == PH_CRLF)
        else $error("trailer count set outside CR LF phase");

    // Payload never coincides with done or error
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.out_valid |-> !result.done_res && !result.format_error)
        else $error("payload flagged with done or error");

    // Done and error are exclusive
    a_done_err: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.done_res && result.format_error))
        else $error("done and error both set");

    // Empty output register never stalls the request side
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> body.ready)
        else $error("stalled with empty result register");

endmodule

// File: hdl/hcd_byte_class.sv
// Byte classifier: hex digit value, blank, CR and LF detection.
`timescale 1ns / 1ps

module hcd_byte_class
    import hcd_pkg::*;
(
    input  logic [7:0] byte_in,
    output hcd_class_t cls
);

    logic [7:0] off_digit;
    logic [7:0] off_lower;
    logic [7:0] off_upper;

    // Subtract a base per range so the low nibble is the hex value (a and A give 10)
    assign off_digit = byte_in - 8'h30;
    assign off_lower = byte_in - 8'h57;
    assign off_upper = byte_in - 8'h37;

    // Decode hex digit and its value
    always_comb
    begin
        cls.is_hex  = 1'b1;
        cls.hex_val = 4'h0;
        if (byte_in >= 8'h30 && byte_in <= 8'h39)
        begin
            cls.hex_val = off_digit[3:0];
        end
        else if (byte_in >= 8'h61 && byte_in <= 8'h66)
        begin
            cls.hex_val = off_lower[3:0];
        end
        else if (byte_in >= 8'h41 && byte_in <= 8'h46)
        begin
            cls.hex_val = off_upper[3:0];
        end
        else
        begin
            cls.is_hex = 1'b0;
        end
        cls.is_blank = (byte_in == CHAR_SPACE) || (byte_in == CHAR_TAB);
        cls.is_cr    = (byte_in == CHAR_CR);
        cls.is_lf    = (byte_in == CHAR_LF);
    end

endmodule
